// ===== sv/jst_pkg.sv =====
// jst_pkg: shared types and constants for the json structural tokenizer
// token kinds, character codes, sizes and the token record
// no dependencies
package jst_pkg;

  localparam int POS_BITS   = 16;
  localparam int MAX_DEPTH  = 255;
  localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);

  localparam int CHAR_BITS  = 16;
  localparam int START_BITS = 16;
  localparam int END_BITS   = 17;
  localparam int LEVEL_BITS = 9;

  // output queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // stream word widths
  localparam int IN_TDATA_BITS   = 16;
  localparam int OUT_TDATA_BITS  = 48;
  localparam int OUT_TUSER_BITS  = 4;
  localparam int OUT_TDATA_USED  = START_BITS + END_BITS + LEVEL_BITS;

  typedef enum logic [2:0] {
    TK_VALUE     = 3'd0,
    TK_KEY       = 3'd1,
    TK_OPEN_OBJ  = 3'd2,
    TK_CLOSE_OBJ = 3'd3,
    TK_OPEN_ARR  = 3'd4,
    TK_CLOSE_ARR = 3'd5,
    TK_COMMA     = 3'd6
  } tok_kind_t;

  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 16'h0020;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 16'h0009;
  localparam logic [CHAR_BITS-1:0] CH_LF     = 16'h000A;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 16'h000D;
  localparam logic [CHAR_BITS-1:0] CH_LBRACK = 16'h005B;
  localparam logic [CHAR_BITS-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CHAR_BITS-1:0] CH_RBRACK = 16'h005D;
  localparam logic [CHAR_BITS-1:0] CH_RBRACE = 16'h007D;
  localparam logic [CHAR_BITS-1:0] CH_COMMA  = 16'h002C;
  localparam logic [CHAR_BITS-1:0] CH_COLON  = 16'h003A;
  localparam logic [CHAR_BITS-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [CHAR_BITS-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [CHAR_BITS-1:0] CH_BSLASH = 16'h005C;

  typedef struct packed {
    tok_kind_t                    kind;
    logic [START_BITS-1:0]        start_pos;
    logic signed [END_BITS-1:0]   end_pos;
    logic [LEVEL_BITS-1:0]        nest_level;
    logic                         depth_fault;
    logic                         run_end;
  } token_t;

endpackage

// ===== sv/json_structural_tokenizer_unit.sv =====
// json_structural_tokenizer_unit: character stream in, structural token stream out
// scans one character per word and queues up to two tokens per character
// depends on jst_pkg
//
//  channel | dir | tdata (low bit up)                      | tuser                    | tlast
//  in_     | in  | char_code[15:0]                         | -                        | end_of_text
//  out_    | out | start_pos, end_pos, nest_level, zeros   | token_kind, depth_fault  | run_end
//
// one character is taken per cycle while in_tready is high; the scan is a few
// compares between the input port and a four-entry token queue, so a character's
// tokens are queued on the edge that accepts it and can leave on the next cycle
// a character that yields a value token plus a close or comma queues two tokens,
// which leave one at a time; in_tready drops while fewer than two queue slots are free
// rst_n is synchronous and active low; it clears the scan state and empties the queue
// out_tready low fills the queue, and the scan then stalls through in_tready
module json_structural_tokenizer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [jst_pkg::IN_TDATA_BITS-1:0]    in_tdata,  // char_code[15:0]
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [jst_pkg::OUT_TDATA_BITS-1:0]   out_tdata, // start_pos[15:0], end_pos[32:16],
                                                          // nest_level[41:33], zero[47:42]
  output logic [jst_pkg::OUT_TUSER_BITS-1:0]   out_tuser, // token_kind[2:0], depth_fault[3]
  output logic                                 out_tlast
);

  // scan state
  logic                              esc_r, esc_nxt;
  logic                              quote_r, quote_nxt;
  logic                              single_r, single_nxt;
  logic [jst_pkg::DEPTH_BITS-1:0]    depth_r, depth_nxt;
  logic [jst_pkg::POS_BITS-1:0]      pos_r, pos_nxt;
  logic [jst_pkg::POS_BITS-1:0]      seg_r, seg_nxt;
  logic                              text_r, text_nxt;

  // token queue
  jst_pkg::token_t                   queue_r [jst_pkg::QUEUE_DEPTH];
  logic [jst_pkg::QPTR_BITS-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [jst_pkg::QPTR_BITS-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [jst_pkg::QCNT_BITS-1:0]     count_r, count_nxt;

  logic                              in_fire, out_fire;
  logic [jst_pkg::CHAR_BITS-1:0]     ch;
  logic                              is_quote, structural, is_blank;
  logic                              is_open, is_close, closes, value_first;
  logic [1:0]                        n_tok;
  logic [jst_pkg::START_BITS-1:0]    pos_lo;
  logic signed [jst_pkg::END_BITS-1:0] pos_prev;
  jst_pkg::token_t                   tok_val, tok_str, head;

  assign in_tready  = count_r <= jst_pkg::QCNT_BITS'(jst_pkg::QUEUE_DEPTH - 2);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = count_r != '0;
  assign out_fire   = out_tvalid && out_tready;
  assign ch         = in_tdata[jst_pkg::CHAR_BITS-1:0];

  // character classification and quote / escape tracking
  always_comb begin
    is_quote   = (ch == jst_pkg::CH_DQUOTE) || (ch == jst_pkg::CH_SQUOTE);
    is_blank   = ch inside {jst_pkg::CH_SPACE, jst_pkg::CH_TAB, jst_pkg::CH_LF,
                            jst_pkg::CH_CR};
    esc_nxt    = esc_r;
    quote_nxt  = quote_r;
    single_nxt = single_r;
    structural = 1'b0;
    if (esc_r) begin
      esc_nxt = 1'b0;
    end else if (ch == jst_pkg::CH_BSLASH) begin
      esc_nxt = 1'b1;
    end else if (is_quote && !quote_r) begin
      quote_nxt  = 1'b1;
      single_nxt = (ch == jst_pkg::CH_SQUOTE);
    end else if (is_quote && ((ch == jst_pkg::CH_SQUOTE) == single_r)) begin
      quote_nxt = 1'b0;
    end else if (!quote_r) begin
      structural = ch inside {jst_pkg::CH_LBRACK, jst_pkg::CH_LBRACE,
                              jst_pkg::CH_RBRACK, jst_pkg::CH_RBRACE,
                              jst_pkg::CH_COMMA, jst_pkg::CH_COLON};
    end
  end

  // token build
  always_comb begin
    is_open     = (ch == jst_pkg::CH_LBRACE) || (ch == jst_pkg::CH_LBRACK);
    is_close    = (ch == jst_pkg::CH_RBRACE) || (ch == jst_pkg::CH_RBRACK);
    closes      = is_close || (ch == jst_pkg::CH_COMMA);
    value_first = structural && closes && text_r;
    n_tok       = structural ? (value_first ? 2'd2 : 2'd1) : 2'd0;
    pos_lo      = jst_pkg::START_BITS'(pos_r);
    // position minus one, -1 when the position is zero
    pos_prev    = jst_pkg::END_BITS'(pos_r) - jst_pkg::END_BITS'(1);

    tok_val.kind        = jst_pkg::TK_VALUE;
    tok_val.start_pos   = jst_pkg::START_BITS'(seg_r);
    tok_val.end_pos     = pos_prev;
    tok_val.nest_level  = jst_pkg::LEVEL_BITS'(depth_r) + jst_pkg::LEVEL_BITS'(1);
    tok_val.depth_fault = 1'b0;
    tok_val.run_end     = 1'b0;

    tok_str.start_pos   = pos_lo;
    tok_str.end_pos     = signed'(jst_pkg::END_BITS'(pos_lo));
    tok_str.nest_level  = jst_pkg::LEVEL_BITS'(depth_r);
    tok_str.depth_fault = 1'b0;
    tok_str.run_end     = 1'b1;
    depth_nxt           = depth_r;

    if (is_open) begin
      tok_str.kind = (ch == jst_pkg::CH_LBRACE) ? jst_pkg::TK_OPEN_OBJ : jst_pkg::TK_OPEN_ARR;
      if (depth_r >= jst_pkg::DEPTH_BITS'(jst_pkg::MAX_DEPTH)) begin
        tok_str.depth_fault = 1'b1;
        tok_str.nest_level  = jst_pkg::LEVEL_BITS'(jst_pkg::MAX_DEPTH);
      end else begin
        depth_nxt          = depth_r + jst_pkg::DEPTH_BITS'(1);
        tok_str.nest_level = jst_pkg::LEVEL_BITS'(depth_nxt);
      end
    end else if (is_close) begin
      tok_str.kind = (ch == jst_pkg::CH_RBRACE) ? jst_pkg::TK_CLOSE_OBJ : jst_pkg::TK_CLOSE_ARR;
      // close records the depth before closing
      if (depth_r == '0) begin
        tok_str.depth_fault = 1'b1;
      end else begin
        depth_nxt = depth_r - jst_pkg::DEPTH_BITS'(1);
      end
    end else if (ch == jst_pkg::CH_COLON) begin
      // key spans the segment, empty key gives end = start - 1
      tok_str.kind      = jst_pkg::TK_KEY;
      tok_str.start_pos = jst_pkg::START_BITS'(seg_r);
      tok_str.end_pos   = pos_prev;
    end else begin
      tok_str.kind = jst_pkg::TK_COMMA;
    end

    if (!structural) begin
      depth_nxt = depth_r;
    end
  end

  // segment and position update, cleared after end of text
  always_comb begin
    seg_nxt  = seg_r;
    text_nxt = text_r;
    pos_nxt  = pos_r + jst_pkg::POS_BITS'(1);
    if (structural) begin
      seg_nxt  = pos_r + jst_pkg::POS_BITS'(1);
      text_nxt = 1'b0;
    end else if (!is_blank) begin
      text_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 1'b0;
      quote_r  <= 1'b0;
      single_r <= 1'b0;
      depth_r  <= '0;
      pos_r    <= '0;
      seg_r    <= '0;
      text_r   <= 1'b0;
    end else if (in_fire) begin
      if (in_tlast) begin
        esc_r    <= 1'b0;
        quote_r  <= 1'b0;
        single_r <= 1'b0;
        depth_r  <= '0;
        pos_r    <= '0;
        seg_r    <= '0;
        text_r   <= 1'b0;
      end else begin
        esc_r    <= esc_nxt;
        quote_r  <= quote_nxt;
        single_r <= single_nxt;
        depth_r  <= depth_nxt;
        pos_r    <= pos_nxt;
        seg_r    <= seg_nxt;
        text_r   <= text_nxt;
      end
    end
  end

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + jst_pkg::QPTR_BITS'(n_tok);
      count_nxt  = count_r + jst_pkg::QCNT_BITS'(n_tok);
    end
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + jst_pkg::QPTR_BITS'(1);
      count_nxt  = count_nxt - jst_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage, value token goes ahead of the structural one
  always_ff @(posedge clk) begin
    if (in_fire && structural) begin
      if (value_first) begin
        queue_r[wr_ptr_r]                           <= tok_val;
        queue_r[wr_ptr_r + jst_pkg::QPTR_BITS'(1)]  <= tok_str;
      end else begin
        queue_r[wr_ptr_r] <= tok_str;
      end
    end
  end

  assign head      = queue_r[rd_ptr_r];
  assign out_tdata = {(jst_pkg::OUT_TDATA_BITS - jst_pkg::OUT_TDATA_USED)'(0),
                      head.nest_level, head.end_pos, head.start_pos};
  assign out_tuser = {head.depth_fault, head.kind};
  assign out_tlast = head.run_end;

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= jst_pkg::QCNT_BITS'(jst_pkg::QUEUE_DEPTH))
    else $error("token queue overfilled");

  // nesting depth stays within MAX_DEPTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= jst_pkg::DEPTH_BITS'(jst_pkg::MAX_DEPTH))
    else $error("depth beyond its limit");

  // end of text leaves a clean scan state
  a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> pos_r == '0 && depth_r == '0 && !quote_r && !esc_r && !text_r)
    else $error("scan state not cleared after end of text");

  // a two-token character writes a value token that is not the run end
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && n_tok == 2'd2 |=> queue_r[$past(wr_ptr_r)].kind == jst_pkg::TK_VALUE
      && !queue_r[$past(wr_ptr_r)].run_end)
    else $error("token pair written out of order");

endmodule
